### rtl/core/lfcr_pkg.sv
// shared types, constants and helpers for the langevin force chain block
package lfcr_pkg;

    localparam int LFCR_MAX_CHAINS = 256;
    localparam int DIV_STEPS = 17;
    localparam int SQRT_STEPS = 24;

    localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [42:0] FRIC_CAP = 43'd4398046511104;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_THERMO = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_SAT   = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        CFG_GAMMA  = 3'd0,
        CFG_SCALE  = 3'd1,
        CFG_BOOST  = 3'd2,
        CFG_LENGTH = 3'd3,
        CFG_COUNT  = 3'd4,
        CFG_RECIP  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] friction_gamma;
        logic [31:0] noise_scale;
        logic        heat_boost;
        logic [15:0] chain_length;
        logic [8:0]  chain_count;
        logic [31:0] chain_length_recip;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_DIV, OP_READ, OP_GRAB, OP_SQRT,
        OP_BOOST, OP_SCALE, OP_FA, OP_FL, OP_FH, OP_FS, OP_NT, OP_NE, OP_UPD,
        OP_MA, OP_ML, OP_MH, OP_MQ, OP_MR, OP_WRITE, OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] comp;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  chain_ok;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_DIV, S_CHECK, S_GRAB, S_SQRT, S_BOOST, S_SCALE,
        S_FA, S_FL, S_FH, S_FS, S_NT, S_NE, S_UPD,
        S_MA, S_ML, S_MH, S_MQ, S_MR, S_WRITE, S_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX)
            r = 32'sh7FFF_FFFF;
        else if (x < S32_MIN)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [63:0] x);
        return (x > S32_MAX) || (x < S32_MIN);
    endfunction

endpackage

### rtl/core/lfcr_cfg.sv
// configuration register bank
module lfcr_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output lfcr_pkg::cfg_t cfg
);
    import lfcr_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.friction_gamma     <= '0;
            cfg_reg.noise_scale        <= '0;
            cfg_reg.heat_boost         <= 1'b0;
            cfg_reg.chain_length       <= 16'd1;
            cfg_reg.chain_count        <= 9'd1;
            cfg_reg.chain_length_recip <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAMMA:  cfg_reg.friction_gamma     <= cfg_data;
                CFG_SCALE:  cfg_reg.noise_scale        <= cfg_data;
                CFG_BOOST:  cfg_reg.heat_boost         <= cfg_data[0];
                CFG_LENGTH: cfg_reg.chain_length       <= cfg_data[15:0];
                CFG_COUNT:  cfg_reg.chain_count        <= cfg_data[8:0];
                CFG_RECIP:  cfg_reg.chain_length_recip <= cfg_data;
                default:    ;
            endcase
        end
    end

endmodule

### rtl/core/lfcr_dp.sv
// datapath: divider, square root, shared multiplier, accumulator memory
module lfcr_dp #(
    parameter int MAX_CHAINS = lfcr_pkg::LFCR_MAX_CHAINS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lfcr_pkg::dp_cmd_t  cmd,
    input  lfcr_pkg::cfg_t     cfg,
    input  logic [1:0]         mode,
    input  logic [16:0]        particle_index,
    input  logic [31:0]        mass,
    input  logic signed [31:0] velocity_x,
    input  logic signed [31:0] velocity_y,
    input  logic signed [31:0] velocity_z,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic [15:0]        rand_x,
    input  logic [15:0]        rand_y,
    input  logic [15:0]        rand_z,
    output lfcr_pkg::dp_stat_t stat,
    output logic signed [31:0] new_force_x,
    output logic signed [31:0] new_force_y,
    output logic signed [31:0] new_force_z,
    output logic [7:0]         chain_number,
    output logic [1:0]         status
);
    import lfcr_pkg::*;

    localparam int AW = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
    localparam logic [16:0] CHAINS_LIM = 17'(MAX_CHAINS);

    mode_t              mode_reg;
    logic [16:0]        idx_reg;
    logic [31:0]        mass_reg;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] frc_reg [3];
    logic signed [31:0] res_reg [3];
    logic [15:0]        rnd_reg [3];
    logic [16:0]        dvd_reg;
    logic [15:0]        rem_reg;
    logic [47:0]        sq_rem_reg;
    logic [47:0]        sq_res_reg;
    logic [47:0]        sq_bit_reg;
    logic signed [67:0] prod_reg;
    logic [32:0]        scale_reg;
    logic [47:0]        a_reg;
    logic [47:0]        lo_reg;
    logic [64:0]        fsum_reg;
    logic signed [43:0] fr_reg;
    logic signed [31:0] e_reg;
    logic signed [47:0] acc_reg [3];
    logic [47:0]        mag_reg;
    logic               neg_reg;
    logic signed [49:0] mean_reg;
    logic               sat_reg;

    logic [143:0]          mem [MAX_CHAINS];
    logic [143:0]          rd_reg;
    logic                  rd_vld_reg;
    logic [MAX_CHAINS-1:0] vld_reg;

    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic [7:0]         cn_reg;
    logic [1:0]         st_reg;

    logic [15:0]        len;
    logic [16:0]        trial;
    logic [16:0]        diff;
    logic               ge;
    logic               idx_zero;
    logic               chain_ok;
    logic [AW-1:0]      addr;
    logic [48:0]        sq_sum;
    logic               sq_ge;
    logic [1:0]         comp;
    logic signed [31:0] vel_c;
    logic signed [31:0] frc_c;
    logic signed [47:0] acc_c;
    logic [32:0]        vneg;
    logic [31:0]        av;
    logic signed [16:0] rc;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic               mul_en;
    logic [42:0]        fric_mag;
    logic signed [43:0] fr_pos;
    logic signed [43:0] fr_next;
    logic signed [41:0] noise;
    logic signed [45:0] e_wide;
    logic signed [32:0] r_wide;
    logic signed [48:0] acc_wide;
    logic               acc_ovf;
    logic signed [47:0] acc_clamp;
    logic [47:0]        acc_neg;
    logic [48:0]        q;
    logic signed [49:0] q_s;
    logic signed [50:0] mr_wide;
    logic [7:0]         cn_val;

    assign len      = (cfg.chain_length == 16'd0) ? 16'd1 : cfg.chain_length;
    assign trial    = {rem_reg, dvd_reg[16]};
    assign diff     = trial - {1'b0, len};
    assign ge       = trial >= {1'b0, len};
    assign idx_zero = (idx_reg == 17'd0);
    assign chain_ok = !idx_zero && (dvd_reg < {8'd0, cfg.chain_count})
                      && (dvd_reg < CHAINS_LIM);
    assign addr     = dvd_reg[AW-1:0];
    assign cn_val   = (idx_zero || (dvd_reg > 17'd255)) ? 8'd255 : dvd_reg[7:0];

    assign stat.mode     = mode_reg;
    assign stat.chain_ok = chain_ok;

    assign sq_sum = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_ge  = {1'b0, sq_rem_reg} >= sq_sum;

    assign comp  = cmd.comp;
    assign vel_c = vel_reg[comp];
    assign frc_c = frc_reg[comp];
    assign acc_c = acc_reg[comp];
    assign vneg  = 33'd0 - {vel_c[31], vel_c};
    assign av    = vel_c[31] ? vneg[31:0] : vel_c;
    assign rc    = {1'b0, rnd_reg[comp]} - HALF_Q16;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (cmd.op)
            OP_BOOST:
            begin
                mul_a = {2'b0, cfg.noise_scale};
                mul_b = {3'b0, SQRT3_Q30};
            end
            OP_FA:
            begin
                mul_a = {2'b0, cfg.friction_gamma};
                mul_b = {2'b0, av};
            end
            OP_FL:
            begin
                mul_a = {2'b0, prod_reg[47:16]};
                mul_b = {2'b0, mass_reg};
            end
            OP_FH:
            begin
                mul_a = {18'b0, a_reg[47:32]};
                mul_b = {2'b0, mass_reg};
            end
            OP_FS:
            begin
                mul_a = {1'b0, scale_reg};
                mul_b = {{17{rc[16]}}, rc};
            end
            OP_NT:
            begin
                mul_a = prod_reg[49:16];
                mul_b = {10'b0, sq_res_reg[23:0]};
            end
            OP_ML:
            begin
                mul_a = {2'b0, mag_reg[31:0]};
                mul_b = {2'b0, cfg.chain_length_recip};
            end
            OP_MH:
            begin
                mul_a = {18'b0, mag_reg[47:32]};
                mul_b = {2'b0, cfg.chain_length_recip};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // friction magnitude capped, sign opposite to velocity
    assign fric_mag = (fsum_reg > {22'd0, FRIC_CAP}) ? FRIC_CAP : fsum_reg[42:0];
    assign fr_pos   = {1'b0, fric_mag};
    assign fr_next  = vel_c[31] ? fr_pos : -fr_pos;
    assign noise    = prod_reg[57:16];
    assign e_wide   = 46'(fr_reg) + 46'(noise);
    assign r_wide   = 33'(frc_c) + 33'(e_reg);
    assign acc_wide = 49'(acc_c) + 49'(e_reg);
    assign acc_ovf  = acc_wide[48] != acc_wide[47];
    assign acc_clamp = acc_ovf ? (acc_wide[48] ? S48_MIN : S48_MAX) : acc_wide[47:0];
    assign acc_neg  = 48'd0 - acc_c;
    assign q        = {1'b0, prod_reg[47:0]} + {17'd0, lo_reg[31:0]};
    assign q_s      = {1'b0, q};
    assign mr_wide  = 51'(frc_c) - 51'(mean_reg);

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_p;
        unique case (cmd.op)
            OP_LOAD:
            begin
                mode_reg   <= mode_t'(mode);
                idx_reg    <= particle_index;
                mass_reg   <= mass;
                vel_reg[0] <= velocity_x;
                vel_reg[1] <= velocity_y;
                vel_reg[2] <= velocity_z;
                frc_reg[0] <= force_x;
                frc_reg[1] <= force_y;
                frc_reg[2] <= force_z;
                rnd_reg[0] <= rand_x;
                rnd_reg[1] <= rand_y;
                rnd_reg[2] <= rand_z;
                dvd_reg    <= particle_index - 17'd1;
                rem_reg    <= '0;
                sq_rem_reg <= {mass, 16'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= 48'd1 << 46;
                sat_reg    <= 1'b0;
            end
            OP_DIV:
            begin
                rem_reg <= ge ? diff[15:0] : trial[15:0];
                dvd_reg <= {dvd_reg[15:0], ge};
            end
            OP_GRAB:
            begin
                acc_reg[0] <= rd_vld_reg ? rd_reg[47:0] : '0;
                acc_reg[1] <= rd_vld_reg ? rd_reg[95:48] : '0;
                acc_reg[2] <= rd_vld_reg ? rd_reg[143:96] : '0;
            end
            OP_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_rem_reg <= sq_rem_reg - sq_sum[47:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_SCALE:
                scale_reg <= cfg.heat_boost ? prod_reg[62:30] : {1'b0, cfg.noise_scale};
            OP_FL:
                a_reg <= prod_reg[63:16];
            OP_FH:
                lo_reg <= prod_reg[63:16];
            OP_FS:
                fsum_reg <= {1'b0, prod_reg[47:0], 16'd0} + {17'd0, lo_reg};
            OP_NT:
                fr_reg <= fr_next;
            OP_NE:
            begin
                e_reg   <= sat32(64'(e_wide));
                sat_reg <= sat_reg | ovf32(64'(e_wide));
            end
            OP_UPD:
            begin
                res_reg[comp] <= sat32(64'(r_wide));
                acc_reg[comp] <= acc_clamp;
                sat_reg       <= sat_reg | ovf32(64'(r_wide)) | acc_ovf;
            end
            OP_MA:
            begin
                mag_reg <= acc_c[47] ? acc_neg : acc_c;
                neg_reg <= acc_c[47];
            end
            OP_MH:
                lo_reg <= {16'd0, prod_reg[63:32]};
            OP_MQ:
                mean_reg <= neg_reg ? -q_s : q_s;
            OP_MR:
            begin
                res_reg[comp] <= sat32(64'(mr_wide));
                sat_reg       <= sat_reg | ovf32(64'(mr_wide));
            end
            OP_OUT:
            begin
                if (mode_reg == MODE_CLEAR || mode_reg == MODE_NONE)
                begin
                    fx_reg <= '0;
                    fy_reg <= '0;
                    fz_reg <= '0;
                    cn_reg <= '0;
                    st_reg <= STAT_OK;
                end
                else if (!chain_ok)
                begin
                    fx_reg <= frc_reg[0];
                    fy_reg <= frc_reg[1];
                    fz_reg <= frc_reg[2];
                    cn_reg <= cn_val;
                    st_reg <= STAT_RANGE;
                end
                else
                begin
                    fx_reg <= res_reg[0];
                    fy_reg <= res_reg[1];
                    fz_reg <= res_reg[2];
                    cn_reg <= cn_val;
                    st_reg <= sat_reg ? STAT_SAT : STAT_OK;
                end
            end
            default: ;
        endcase
    end

    // accumulator storage, x in the low third
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE)
            mem[addr] <= {acc_reg[2], acc_reg[1], acc_reg[0]};
        if (cmd.op == OP_READ)
            rd_reg <= mem[addr];
    end

    // an entry not yet written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
                vld_reg <= '0;
            else if (cmd.op == OP_WRITE)
                vld_reg[addr] <= 1'b1;
            if (cmd.op == OP_READ)
                rd_vld_reg <= vld_reg[addr];
        end
    end

    assign new_force_x  = fx_reg;
    assign new_force_y  = fy_reg;
    assign new_force_z  = fz_reg;
    assign chain_number = cn_reg;
    assign status       = st_reg;

endmodule

### rtl/core/lfcr_ctrl.sv
// controller state machine sequencing the datapath
module lfcr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  lfcr_pkg::dp_stat_t stat,
    output lfcr_pkg::dp_cmd_t  cmd
);
    import lfcr_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic       oval_reg, oval_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            oval_reg  <= oval_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        oval_next  = oval_reg && out_stall;
        cmd.op     = OP_NONE;
        cmd.comp   = comp_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = '0;
                if (stat.mode == MODE_CLEAR)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_OUT;
                end
                else if (stat.mode == MODE_NONE)
                    state_next = S_OUT;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = S_CHECK;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_CHECK:
            begin
                if (!stat.chain_ok)
                    state_next = S_OUT;
                else
                begin
                    cmd.op     = OP_READ;
                    state_next = S_GRAB;
                end
            end
            S_GRAB:
            begin
                cmd.op    = OP_GRAB;
                cnt_next  = '0;
                comp_next = '0;
                state_next = (stat.mode == MODE_THERMO) ? S_SQRT : S_MA;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                    state_next = S_BOOST;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_BOOST:
            begin
                cmd.op     = OP_BOOST;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_FA;
            end
            S_FA:
            begin
                cmd.op     = OP_FA;
                state_next = S_FL;
            end
            S_FL:
            begin
                cmd.op     = OP_FL;
                state_next = S_FH;
            end
            S_FH:
            begin
                cmd.op     = OP_FH;
                state_next = S_FS;
            end
            S_FS:
            begin
                cmd.op     = OP_FS;
                state_next = S_NT;
            end
            S_NT:
            begin
                cmd.op     = OP_NT;
                state_next = S_NE;
            end
            S_NE:
            begin
                cmd.op     = OP_NE;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op = OP_UPD;
                if (comp_reg == 2'd2)
                    state_next = S_WRITE;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_FA;
                end
            end
            S_MA:
            begin
                cmd.op     = OP_MA;
                state_next = S_ML;
            end
            S_ML:
            begin
                cmd.op     = OP_ML;
                state_next = S_MH;
            end
            S_MH:
            begin
                cmd.op     = OP_MH;
                state_next = S_MQ;
            end
            S_MQ:
            begin
                cmd.op     = OP_MQ;
                state_next = S_MR;
            end
            S_MR:
            begin
                cmd.op = OP_MR;
                if (comp_reg == 2'd2)
                    state_next = S_OUT;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_MA;
                end
            end
            S_WRITE:
            begin
                cmd.op     = OP_WRITE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!oval_reg || !out_stall)
                begin
                    cmd.op     = OP_OUT;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = oval_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a transaction is in flight");

    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        comp_reg != 2'd3)
        else $error("component counter out of range");

    a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_WRITE |-> stat.mode == MODE_THERMO && stat.chain_ok)
        else $error("accumulator write outside a valid thermostat pass");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |=> out_valid && state_reg == S_IDLE)
        else $error("result load did not raise out_valid");

endmodule

### rtl/core/langevin_force_chain_cm_removal_top.sv
// top level: langevin thermostat with per-chain mean excess force removal
//
//  channel  handshake              payload
//  in       in_valid / in_stall    mode, particle_index, mass, velocity_*, force_*, rand_*
//  out      out_valid / out_stall  new_force_*, chain_number, status
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction at a time. thermostat: 17-step divider, 24-step square root, shared
// 34x34 multiplier run once for the boost and 5 times per component. chain mean removal
// also runs the divider first; a chain out of range stops after the divider; clear or
// unused mode goes straight to the output.
// reset zeroes the accumulator valid bits at once, no clearing pass.
// a finished result waits in the output register while the next transaction runs.
module langevin_force_chain_cm_removal_top #(
    parameter int MAX_CHAINS = lfcr_pkg::LFCR_MAX_CHAINS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [16:0]        particle_index,
    input  logic [31:0]        mass,
    input  logic signed [31:0] velocity_x,
    input  logic signed [31:0] velocity_y,
    input  logic signed [31:0] velocity_z,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic [15:0]        rand_x,
    input  logic [15:0]        rand_y,
    input  logic [15:0]        rand_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_force_x,
    output logic signed [31:0] new_force_y,
    output logic signed [31:0] new_force_z,
    output logic [7:0]         chain_number,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import lfcr_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    lfcr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfcr_dp #(
        .MAX_CHAINS (MAX_CHAINS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .mode           (mode),
        .particle_index (particle_index),
        .mass           (mass),
        .velocity_x     (velocity_x),
        .velocity_y     (velocity_y),
        .velocity_z     (velocity_z),
        .force_x        (force_x),
        .force_y        (force_y),
        .force_z        (force_z),
        .rand_x         (rand_x),
        .rand_y         (rand_y),
        .rand_z         (rand_z),
        .stat           (stat),
        .new_force_x    (new_force_x),
        .new_force_y    (new_force_y),
        .new_force_z    (new_force_z),
        .chain_number   (chain_number),
        .status         (status)
    );

endmodule
